### rtl/smpd_pkg.sv
// shared types and constants of the sync marker packet deframer
`timescale 1ns / 1ps
package smpd_pkg;
   localparam int LENGTH_BITS = 24;
   localparam logic [15:0] SYNC_MARK = 16'hFFFE;
   localparam logic [15:0] MAX_COUNT_RESET = 16'd200;
   localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
   localparam logic [23:0] REPORT_MAX = 24'hFFFFFF;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_ABITS = 2;

   typedef enum logic [1:0] {
      MODE_SEARCH = 2'd0,
      MODE_HEADER = 2'd1,
      MODE_BODY   = 2'd2,
      MODE_SPARE  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      BK_IDLE   = 2'd0,
      BK_DIVIDE = 2'd1,
      BK_EMIT   = 2'd2
   } back_state_type;

   // one classified request from the front part
   typedef struct packed {
      logic        is_data;
      logic [7:0]  leaving;
      logic        is_field;
      logic [1:0]  field_index;
      logic [15:0] field_value;
      logic        is_sync;
      logic        open;
   } cmd_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  out_byte;
      logic        last_of_run;
      logic [23:0] packet_length;
      logic        drop;
      logic [14:0] frame_width;
      logic [14:0] frame_height;
      logic [15:0] aligned_width;
      logic [15:0] aligned_height;
      logic [14:0] block_width;
      logic [14:0] block_height;
      logic [15:0] block_count;
   } rsp_type;
endpackage

### rtl/smpd_front.sv
// front part: sync search, header byte tracking and classification
`timescale 1ns / 1ps
module smpd_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                take,
   input  logic [7:0]          data_byte,
   input  logic [15:0]         max_block_count,
   output smpd_pkg::cmd_type   cmd
);
   logic [31:0]             window_ff, window_in;
   logic [2:0]              fill_ff, fill_in;
   smpd_pkg::mode_type      mode_ff, mode_in;
   logic [3:0]              hidx_ff, hidx_in;
   logic [15:0]             locked_ff, locked_in;
   logic [2:0]              fill_next;
   logic                    sync_ok;
   logic [15:0]             count;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         fill_ff   <= '0;
         mode_ff   <= smpd_pkg::MODE_SEARCH;
         hidx_ff   <= '0;
         locked_ff <= '0;
      end else if (take) begin
         window_ff <= window_in;
         fill_ff   <= fill_in;
         mode_ff   <= mode_in;
         hidx_ff   <= hidx_in;
         locked_ff <= locked_in;
      end
   end

   // classify the byte and advance the search
   always_comb begin
      window_in = {window_ff[23:0], data_byte};
      count     = window_in[15:0];
      fill_next = (fill_ff < 3'd4) ? fill_ff + 3'd1 : fill_ff;
      sync_ok   = (fill_next >= 3'd4) && (window_in[31:16] == smpd_pkg::SYNC_MARK)
                  && (count != 16'd0) && (count <= max_block_count)
                  && ((locked_ff == 16'd0) || (locked_ff == count));
      fill_in   = fill_ff;
      mode_in   = mode_ff;
      hidx_in   = hidx_ff;
      locked_in = locked_ff;
      cmd       = '0;
      cmd.leaving     = window_ff[31:24];
      cmd.field_value = window_in[15:0];
      cmd.field_index = hidx_ff[2:1];
      unique case (mode_ff)
         smpd_pkg::MODE_HEADER: begin
            cmd.is_data  = 1'b1;
            cmd.is_field = hidx_ff[0];
            hidx_in = hidx_ff + 4'd1;
            if (hidx_in >= 4'd8) begin
               mode_in = smpd_pkg::MODE_BODY;
               hidx_in = '0;
               fill_in = '0;
            end
         end
         smpd_pkg::MODE_BODY: begin
            cmd.is_data = 1'b1;
            fill_in = fill_next;
            if (sync_ok) begin
               cmd.is_sync = 1'b1;
               cmd.open    = 1'b1;
               locked_in   = count;
               mode_in     = smpd_pkg::MODE_HEADER;
               hidx_in     = '0;
            end
         end
         default: begin
            mode_in = smpd_pkg::MODE_SEARCH;
            fill_in = fill_next;
            if (sync_ok) begin
               cmd.open  = 1'b1;
               locked_in = count;
               mode_in   = smpd_pkg::MODE_HEADER;
               hidx_in   = '0;
            end
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      cmd.is_sync |-> cmd.is_data && cmd.open) else $error("sync without data");
   assert property (@(posedge clock) disable iff (reset)
      cmd.is_field |-> mode_ff == smpd_pkg::MODE_HEADER) else $error("field outside header");
   assert property (@(posedge clock) disable iff (reset)
      take && cmd.open |=> mode_ff == smpd_pkg::MODE_HEADER && hidx_ff == 4'd0)
      else $error("open did not enter header");
endmodule

### rtl/smpd_queue.sv
// short command queue between front and back
`timescale 1ns / 1ps
module smpd_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  smpd_pkg::cmd_type   push_data,
   input  logic                pop,
   output smpd_pkg::cmd_type   head,
   output logic                empty,
   output logic                full
);
   smpd_pkg::cmd_type                 mem_ff [smpd_pkg::QUEUE_DEPTH];
   logic [smpd_pkg::QUEUE_ABITS-1:0]  wr_ff, rd_ff;
   logic [smpd_pkg::QUEUE_ABITS:0]    cnt_ff;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ff] <= push_data;
   end

   // pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) wr_ff <= wr_ff + 1'b1;
         if (pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + {{smpd_pkg::QUEUE_ABITS{1'b0}}, push}
                          - {{smpd_pkg::QUEUE_ABITS{1'b0}}, pop};
      end
   end

   assign head  = mem_ff[rd_ff];
   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == (smpd_pkg::QUEUE_ABITS+1)'(smpd_pkg::QUEUE_DEPTH));

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (smpd_pkg::QUEUE_ABITS+1)'(smpd_pkg::QUEUE_DEPTH)) else $error("queue overflow");
   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> !empty) else $error("queue lost request");
endmodule

### rtl/smpd_back.sv
// back part: header checks, round-up divider and result output
`timescale 1ns / 1ps
module smpd_back (
   input  logic                clock,
   input  logic                reset,
   input  smpd_pkg::cmd_type   head,
   input  logic                head_valid,
   output logic                head_pop,
   output smpd_pkg::rsp_type   rsp,
   output logic                rsp_empty,
   input  logic                rsp_pop
);
   smpd_pkg::back_state_type       st_ff, st_in;
   logic [smpd_pkg::LENGTH_BITS-1:0] len_ff, len_in;
   logic                           err_ff, err_in;
   logic [14:0] sw_ff, sw_in, sh_ff, sh_in, sbw_ff, sbw_in, sbh_ff, sbh_in;
   logic [15:0] scw_ff, scw_in, sch_ff, sch_in;
   // divider
   logic [15:0] quo_ff, quo_in;
   logic [16:0] rem_ff, rem_in;
   logic [14:0] div_ff, div_in;
   logic [4:0]  step_ff, step_in;
   logic        dfield_ff, dfield_in;
   logic [16:0] trial;
   logic [31:0] prod;
   logic [15:0] coded;
   logic [15:0] num;
   // result registers: data result and pending end record
   smpd_pkg::rsp_type r0_ff, r0_in, r1_ff, r1_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        fv;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= smpd_pkg::BK_IDLE;
         len_ff <= '0; err_ff <= 1'b0;
         sw_ff <= '0; sh_ff <= '0; sbw_ff <= '0; sbh_ff <= '0;
         scw_ff <= '0; sch_ff <= '0;
         cnt_ff <= '0;
      end else begin
         st_ff <= st_in;
         len_ff <= len_in; err_ff <= err_in;
         sw_ff <= sw_in; sh_ff <= sh_in; sbw_ff <= sbw_in; sbh_ff <= sbh_in;
         scw_ff <= scw_in; sch_ff <= sch_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in; rem_ff <= rem_in; div_ff <= div_in;
      step_ff <= step_in; dfield_ff <= dfield_in;
      r0_ff <= r0_in; r1_ff <= r1_in;
   end

   // restoring division of (size + block - 1) by block, one bit a cycle
   assign trial = {rem_ff[15:0], quo_ff[15]} - {2'b0, div_ff};
   assign prod  = quo_ff * {1'b0, div_ff};
   assign coded = prod[15:0];
   assign fv    = (head.field_value != 16'd0) && !head.field_value[15];

   always_comb begin
      st_in = st_ff; len_in = len_ff; err_in = err_ff;
      sw_in = sw_ff; sh_in = sh_ff; sbw_in = sbw_ff; sbh_in = sbh_ff;
      scw_in = scw_ff; sch_in = sch_ff;
      quo_in = quo_ff; rem_in = rem_ff; div_in = div_ff;
      step_in = step_ff; dfield_in = dfield_ff;
      r0_in = r0_ff; r1_in = r1_ff; cnt_in = cnt_ff;
      head_pop = 1'b0;
      num = '0;
      // output shift on pop
      if (rsp_pop && cnt_ff != 2'd0) begin
         r0_in  = r1_ff;
         cnt_in = cnt_ff - 2'd1;
      end
      unique case (st_ff)
         smpd_pkg::BK_DIVIDE: begin
            if (step_ff == 5'd16) begin
               st_in = smpd_pkg::BK_EMIT;
            end else begin
               if (!trial[16]) begin
                  rem_in = trial;
                  quo_in = {quo_ff[14:0], 1'b1};
               end else begin
                  rem_in = {rem_ff[15:0], quo_ff[15]};
                  quo_in = {quo_ff[14:0], 1'b0};
               end
               step_in = step_ff + 5'd1;
            end
         end
         smpd_pkg::BK_EMIT: begin
            // quotient ready: multiply back and check
            if (!dfield_ff) begin
               if (scw_ff != 16'd0 && scw_ff != coded) err_in = 1'b1;
               scw_in = coded;
            end else begin
               if (sch_ff != 16'd0 && sch_ff != coded) err_in = 1'b1;
               sch_in = coded;
            end
            st_in = smpd_pkg::BK_IDLE;
         end
         default: begin
            if (head_valid && cnt_in == 2'd0) begin
               head_pop = 1'b1;
               if (head.is_data) begin
                  if (len_ff != smpd_pkg::LENGTH_MAX) len_in = len_ff + 1'b1;
                  r0_in = '0;
                  r0_in.out_byte    = head.leaving;
                  r0_in.last_of_run = !head.is_sync;
                  cnt_in = 2'd1;
               end
               if (head.is_sync) begin
                  r1_in = '0;
                  r1_in.kind = 1'b1;
                  r1_in.last_of_run = 1'b1;
                  r1_in.packet_length = (len_in > smpd_pkg::LENGTH_BITS'(smpd_pkg::REPORT_MAX))
                     ? smpd_pkg::REPORT_MAX : 24'(len_in);
                  r1_in.drop = err_ff;
                  r1_in.frame_width = sw_ff;
                  r1_in.frame_height = sh_ff;
                  r1_in.aligned_width = scw_ff;
                  r1_in.aligned_height = sch_ff;
                  r1_in.block_width = sbw_ff;
                  r1_in.block_height = sbh_ff;
                  r1_in.block_count = head.field_value;
                  cnt_in = 2'd2;
               end
               if (head.open) begin
                  err_in  = 1'b0;
                  len_in  = '0;
               end
               if (head.is_field) begin
                  if (!fv) begin
                     err_in = 1'b1;
                  end else begin
                     unique case (head.field_index)
                        2'd0: begin
                           if (sw_ff != 15'd0 && sw_ff != head.field_value[14:0]) err_in = 1'b1;
                           sw_in = head.field_value[14:0];
                        end
                        2'd1: begin
                           if (sh_ff != 15'd0 && sh_ff != head.field_value[14:0]) err_in = 1'b1;
                           sh_in = head.field_value[14:0];
                        end
                        default: begin
                           if (head.field_index == 2'd2) begin
                              num = {1'b0, sw_ff} + {1'b0, head.field_value[14:0]} - 16'd1;
                              sbw_in = head.field_value[14:0];
                           end else begin
                              num = {1'b0, sh_ff} + {1'b0, head.field_value[14:0]} - 16'd1;
                              sbh_in = head.field_value[14:0];
                           end
                           quo_in = num;
                           rem_in = '0;
                           div_in = head.field_value[14:0];
                           step_in = '0;
                           dfield_in = head.field_index[0];
                           st_in = smpd_pkg::BK_DIVIDE;
                        end
                     endcase
                  end
               end
            end
         end
      endcase
   end

   assign rsp       = r0_ff;
   assign rsp_empty = (cnt_ff == 2'd0);

   assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid) else $error("pop of empty queue");
   assert property (@(posedge clock) disable iff (reset)
      st_ff == smpd_pkg::BK_DIVIDE |-> div_ff != 15'd0) else $error("divide by zero");
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("result count overflow");
endmodule

### rtl/sync_marker_packet_deframer.sv
// top level of the sync marker packet deframer
`timescale 1ns / 1ps
// path: when idle, a data request passes through its queue entry and then result register r0 to the rsp ports
// throughput: 1 request a cycle while full is low, but a block width or height field holds the back part
//   for its bit-serial round-up division; the 4-entry queue then fills
//   and full rises behind each header until the back part catches up
// reset: synchronous active high; clears search state, stored header, queue, max count 200
module sync_marker_packet_deframer (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   output logic         full,
   input  logic [7:0]   req_data_byte,
   output logic         empty,
   input  logic         pop,
   output logic         rsp_kind,
   output logic [7:0]   rsp_out_byte,
   output logic         rsp_last_of_run,
   output logic [23:0]  rsp_packet_length,
   output logic         rsp_drop,
   output logic [14:0]  rsp_frame_width,
   output logic [14:0]  rsp_frame_height,
   output logic [15:0]  rsp_aligned_width,
   output logic [15:0]  rsp_aligned_height,
   output logic [14:0]  rsp_block_width,
   output logic [14:0]  rsp_block_height,
   output logic [15:0]  rsp_block_count,
   input  logic         csr_write,
   input  logic [15:0]  csr_data
);
   logic [15:0]       max_ff;
   logic              take, q_empty, q_full, q_pop;
   smpd_pkg::cmd_type cmd, head;
   smpd_pkg::rsp_type rsp;

   // configuration register
   always_ff @(posedge clock) begin
      if (reset) max_ff <= smpd_pkg::MAX_COUNT_RESET;
      else if (csr_write) max_ff <= csr_data;
   end

   assign full = q_full;
   assign take = push && !q_full;

   smpd_front u_front (.clock, .reset, .take, .data_byte(req_data_byte),
                       .max_block_count(max_ff), .cmd);

   // only requests that produce work enter the queue
   smpd_queue u_queue (.clock, .reset, .push(take && (cmd.is_data || cmd.open)),
                       .push_data(cmd), .pop(q_pop), .head, .empty(q_empty), .full(q_full));

   smpd_back u_back (.clock, .reset, .head, .head_valid(!q_empty), .head_pop(q_pop),
                     .rsp, .rsp_empty(empty), .rsp_pop(pop));

   assign rsp_kind           = rsp.kind;
   assign rsp_out_byte       = rsp.out_byte;
   assign rsp_last_of_run    = rsp.last_of_run;
   assign rsp_packet_length  = rsp.packet_length;
   assign rsp_drop           = rsp.drop;
   assign rsp_frame_width    = rsp.frame_width;
   assign rsp_frame_height   = rsp.frame_height;
   assign rsp_aligned_width  = rsp.aligned_width;
   assign rsp_aligned_height = rsp.aligned_height;
   assign rsp_block_width    = rsp.block_width;
   assign rsp_block_height   = rsp.block_height;
   assign rsp_block_count    = rsp.block_count;
endmodule
